// ----- hdl/bmhq_pkg.sv -----
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared sizes, entry type, codes and sequencer states of the heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

	// Store sizing
	localparam int CAPACITY     = 1024;
	localparam int IDX_W        = $clog2(CAPACITY);
	localparam int CNT_W        = $clog2(CAPACITY + 1);
	localparam int PAYLOAD_BITS = 16;

	// Port field widths
	localparam int OP_W   = 2;
	localparam int PRIO_W = 32;
	localparam int TAG_W  = 16;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 11;

	// One stored entry
	typedef struct packed {
		logic signed [PRIO_W-1:0]     prio;
		logic [PAYLOAD_BITS-1:0]      tag;
	} entry_t;

	// Request codes
	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 2'd0,
		OP_EXTRACT = 2'd1,
		OP_PEEK    = 2'd2
	} op_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_CHK,
		S_UP_CMP,
		S_RD_ROOT,
		S_RD_LAST,
		S_DN_L,
		S_DN_R,
		S_DN_CMP,
		S_DONE
	} state_t;

endpackage

// ----- hdl/bmhq_req_if.sv -----
// ----------------------------------------------------------------------------
// bmhq_req_if
// Request channel: valid/ready handshake with opcode, priority and payload.
// ----------------------------------------------------------------------------
interface bmhq_req_if;
	import bmhq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          opcode;
	logic signed [PRIO_W-1:0] key_priority;
	logic [TAG_W-1:0]         payload_handle;

	modport source (output valid, opcode, key_priority, payload_handle, input ready);
	modport sink   (input valid, opcode, key_priority, payload_handle, output ready);
endinterface

// ----- hdl/bmhq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bmhq_rsp_if
// Response channel: valid/ready handshake with status, top entry and count.
// ----------------------------------------------------------------------------
interface bmhq_rsp_if;
	import bmhq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [PRIO_W-1:0] top_priority;
	logic [TAG_W-1:0]         top_payload;
	logic [OCC_W-1:0]         occupancy;

	modport source (output valid, status, top_priority, top_payload, occupancy, input ready);
	modport sink   (input valid, status, top_priority, top_payload, occupancy, output ready);
endinterface

// ----- hdl/binary_max_heap_queue.sv -----
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Binary max-heap priority queue over a single-port-write, registered-read
// memory, driven by a small sequencer with one shared signed comparator.
// ----------------------------------------------------------------------------
// One request is taken at a time; req.ready is high only while the sequencer
// is idle, and a finished result waits in the output register so the next
// request can be taken before rsp is drained. Every step that reads the store
// costs one memory read round trip. Insert climbs from the new leaf towards
// the root; extract reports the root, then takes the last entry as the moving
// entry and sifts it down from the root (it reads only the root when it
// removes the only entry); peek reads the root only; an error or unused code
// reads nothing. A result that cannot enter a still full output register
// waits in the done state while rsp stays stalled. Equal priorities are never
// exchanged. The store is not cleared at reset; only entries below the count
// are ever read.
module binary_max_heap_queue (
	input  logic               clk,
	input  logic               arst_n,
	bmhq_req_if.sink           req,
	bmhq_rsp_if.source         rsp
);
	import bmhq_pkg::*;

	// Heap store
	entry_t mem [CAPACITY];
	entry_t rdata_q;
	logic             mem_we, mem_re;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;
	entry_t           mem_wdata;

	// Sequencer and datapath registers
	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [OP_W-1:0]  op_q, op_d;
	logic [IDX_W-1:0] pos_q, pos_d;
	entry_t           cur_q, cur_d;
	entry_t           best_q, best_d;
	logic [IDX_W-1:0] best_idx_q, best_idx_d;
	status_t          res_status_q, res_status_d;
	entry_t           res_top_q, res_top_d;

	// Output register
	logic                     out_valid_q;
	logic [STAT_W-1:0]        out_status_q;
	logic signed [PRIO_W-1:0] out_prio_q;
	logic [TAG_W-1:0]         out_tag_q;
	logic [OCC_W-1:0]         out_occ_q;
	logic                     out_load;

	// Index arithmetic
	logic [IDX_W-1:0] parent_idx;
	logic [CNT_W:0]   left_idx, right_idx;
	logic [CNT_W-1:0] count_dec;

	// Shared comparator
	logic signed [PRIO_W-1:0] cmp_a, cmp_b;
	logic                     cmp_gt;

	assign parent_idx = IDX_W'((pos_q - IDX_W'(1)) >> 1);
	assign left_idx   = {1'b0, pos_q, 1'b1};
	assign right_idx  = {1'b0, pos_q, 1'b0} + (CNT_W + 1)'(2);
	assign count_dec  = count_q - CNT_W'(1);

	// Sift up asks whether the moving entry beats its parent; sift down asks
	// whether the child just read beats the moving entry or the best so far
	assign cmp_a  = (state_q == S_UP_CMP) ? cur_q.prio : rdata_q.prio;
	assign cmp_b  = (state_q == S_UP_CMP) ? rdata_q.prio
		: (state_q == S_DN_CMP) ? best_q.prio : cur_q.prio;
	assign cmp_gt = cmp_a > cmp_b;

	assign req.ready = (state_q == S_IDLE);
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	// Next state and datapath control
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		op_d         = op_q;
		pos_d        = pos_q;
		cur_d        = cur_q;
		best_d       = best_q;
		best_idx_d   = best_idx_q;
		res_status_d = res_status_q;
		res_top_d    = res_top_q;
		mem_we       = 1'b0;
		mem_waddr    = pos_q;
		mem_wdata    = cur_q;
		mem_re       = 1'b0;
		mem_raddr    = parent_idx;

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					op_d         = req.opcode;
					res_status_d = ST_OK;
					res_top_d    = '0;
					state_d      = S_DONE;
					if (req.opcode == OP_INSERT) begin
						if (count_q == CNT_W'(CAPACITY)) begin
							res_status_d = ST_FULL;
						end else begin
							cur_d.prio = req.key_priority;
							cur_d.tag  = req.payload_handle[PAYLOAD_BITS-1:0];
							pos_d      = count_q[IDX_W-1:0];
							count_d    = count_q + CNT_W'(1);
							state_d    = S_UP_CHK;
						end
					end else if (req.opcode == OP_EXTRACT || req.opcode == OP_PEEK) begin
						if (count_q == '0) begin
							res_status_d = ST_EMPTY;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = '0;
							state_d   = S_RD_ROOT;
						end
					end
				end
			end

			// Sift up: hole at pos, moving entry held in cur
			S_UP_CHK: begin
				if (pos_q == '0) begin
					mem_we  = 1'b1;
					state_d = S_DONE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = parent_idx;
					state_d   = S_UP_CMP;
				end
			end

			S_UP_CMP: begin
				mem_we = 1'b1;
				if (cmp_gt) begin
					mem_wdata = rdata_q;
					pos_d     = parent_idx;
					state_d   = S_UP_CHK;
				end else begin
					state_d = S_DONE;
				end
			end

			// Root read back: report it, then for an extract that leaves entries fetch the last entry
			S_RD_ROOT: begin
				res_top_d = rdata_q;
				state_d   = S_DONE;
				if (op_q == OP_EXTRACT) begin
					count_d = count_dec;
					if (count_q != CNT_W'(1)) begin
						mem_re    = 1'b1;
						mem_raddr = count_dec[IDX_W-1:0];
						state_d   = S_RD_LAST;
					end
				end
			end

			S_RD_LAST: begin
				cur_d   = rdata_q;
				pos_d   = '0;
				state_d = S_DN_L;
			end

			// Sift down: fetch left child if it is inside the heap
			S_DN_L: begin
				if (left_idx >= {1'b0, count_q}) begin
					mem_we  = 1'b1;
					state_d = S_DONE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = left_idx[IDX_W-1:0];
					state_d   = S_DN_R;
				end
			end

			// Left child arrived: compare with the moving entry
			S_DN_R: begin
				best_d     = cmp_gt ? rdata_q : cur_q;
				best_idx_d = cmp_gt ? left_idx[IDX_W-1:0] : pos_q;
				if (right_idx < {1'b0, count_q}) begin
					mem_re    = 1'b1;
					mem_raddr = right_idx[IDX_W-1:0];
					state_d   = S_DN_CMP;
				end else if (cmp_gt) begin
					mem_we    = 1'b1;
					mem_wdata = rdata_q;
					pos_d     = left_idx[IDX_W-1:0];
					state_d   = S_DN_L;
				end else begin
					mem_we  = 1'b1;
					state_d = S_DONE;
				end
			end

			// Right child arrived: compare with the best so far
			S_DN_CMP: begin
				mem_we = 1'b1;
				if (cmp_gt) begin
					mem_wdata = rdata_q;
					pos_d     = right_idx[IDX_W-1:0];
					state_d   = S_DN_L;
				end else if (best_idx_q != pos_q) begin
					mem_wdata = best_q;
					pos_d     = best_idx_q;
					state_d   = S_DN_L;
				end else begin
					state_d = S_DONE;
				end
			end

			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath and output payload registers
	always_ff @(posedge clk) begin
		op_q         <= op_d;
		pos_q        <= pos_d;
		cur_q        <= cur_d;
		best_q       <= best_d;
		best_idx_q   <= best_idx_d;
		res_status_q <= res_status_d;
		res_top_q    <= res_top_d;
		if (out_load) begin
			out_status_q <= res_status_q;
			out_prio_q   <= res_top_q.prio;
			out_tag_q    <= TAG_W'(res_top_q.tag);
			out_occ_q    <= OCC_W'(count_q);
		end
	end

	// Heap memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.top_priority = out_prio_q;
	assign rsp.top_payload  = out_tag_q;
	assign rsp.occupancy    = out_occ_q;

endmodule
